@@ src/pcts_pkg.sv @@
// Package: shared constants, types and decode function for the temperature stats unit
package pcts_pkg;
  localparam int NumStationsDef = 32;
  localparam int NumBins = 256;
  localparam int BinBits = 8;
  localparam int CountBitsDef = 16;
  localparam int MinW = 11;
  localparam int SumW = 24;
  localparam int CntOutW = 16;
  localparam int ModeW = 8;
  localparam int MaskW = 32;
  localparam logic signed [MinW-1:0] EMPTY_MIN = 11'sd1000;
  localparam logic signed [MinW-1:0] EMPTY_MAX = -11'sd1000;
  localparam logic signed [SumW-1:0] SUM_HI = 24'sh7fffff;
  localparam logic signed [SumW-1:0] SUM_LO = 24'sh800000;
  localparam logic [7:0] SIGN_BIT = 8'h80;
  localparam logic [7:0] MAG_MASK = 8'h7f;
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef struct packed {
    logic start;
    logic [1:0] req;
    logic station_ok;
  } pcts_cmd_t;

  typedef struct packed {
    logic done;
  } pcts_sts_t;

  function automatic logic signed [ModeW-1:0] decode_temp(input logic [7:0] code);
    logic signed [ModeW-1:0] mag;
    mag = signed'({1'b0, code[6:0] & MAG_MASK[6:0]});
    return (code & SIGN_BIT) != 8'h00 ? -mag : mag;
  endfunction
endpackage

@@ src/pcts_datapath.sv @@
// Datapath: station stores, histogram memory, sample update, clear sweep and mode scan
module pcts_datapath import pcts_pkg::*; #(
  parameter int NUM_STATIONS = NumStationsDef,
  parameter int COUNT_BITS = CountBitsDef,
  localparam int SW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1
) (
  input  logic clk,
  input  logic rst_n,
  input  pcts_cmd_t cmd,
  output pcts_sts_t sts,
  input  logic [SW-1:0] station,
  input  logic [7:0] code,
  output logic signed [MinW-1:0] res_min,
  output logic signed [MinW-1:0] res_max,
  output logic signed [SumW-1:0] res_sum,
  output logic [CntOutW-1:0] res_count,
  output logic signed [ModeW-1:0] res_mode
);
  localparam int HD = NUM_STATIONS * NumBins;
  localparam int HW = SW + BinBits;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // Phases
  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_SAMP = 3'd1;
  localparam logic [2:0] P_SWEEP = 3'd2;
  localparam logic [2:0] P_SCAN = 3'd3;
  localparam logic [2:0] P_TAIL = 3'd4;

  logic signed [MinW-1:0] min_mem [NUM_STATIONS];
  logic signed [MinW-1:0] max_mem [NUM_STATIONS];
  logic signed [SumW-1:0] sum_mem [NUM_STATIONS];
  logic [COUNT_BITS-1:0] cnt_mem [NUM_STATIONS];
  logic [COUNT_BITS-1:0] hist_mem [HD];

  logic [2:0] ph_r, ph_nxt;
  logic [BinBits:0] bin_r, bin_nxt;
  logic [SW-1:0] st_r;
  logic [7:0] code_r;
  logic [COUNT_BITS-1:0] hrd_r;
  logic [BinBits-1:0] rbin_r;
  logic rd_v_r;
  logic [COUNT_BITS-1:0] best_r;
  logic signed [ModeW-1:0] mode_r;
  logic ok_r;
  logic done_r;
  logic init_r;
  logic [SW:0] init_cnt_r;

  logic [HW-1:0] rd_addr;
  logic hw_en;
  logic [HW-1:0] hw_addr;
  logic [COUNT_BITS-1:0] hw_data;
  logic signed [MinW-1:0] t_ext;
  logic signed [SumW:0] sum_w;
  logic hclr_busy;
  logic [HW-1:0] hclr_addr;

  pcts_hclr #(.NUM_STATIONS(NUM_STATIONS)) u_hclr (
    .clk, .rst_n, .busy(hclr_busy), .addr(hclr_addr)
  );

  assign t_ext = MinW'(decode_temp(code_r));
  assign sum_w = {sum_mem[st_r][SumW-1], sum_mem[st_r]} + (SumW+1)'(decode_temp(code_r));

  always_comb begin
    rd_addr = {station, code};
    if (ph_r == P_SCAN) begin
      rd_addr = {st_r, bin_r[BinBits-1:0]};
    end
    hw_en = 1'b0;
    hw_addr = {st_r, code_r};
    hw_data = (hrd_r < CMAX) ? hrd_r + 1'b1 : hrd_r;
    if (ph_r == P_SAMP) begin
      hw_en = 1'b1;
    end else if (ph_r == P_SWEEP) begin
      hw_en = 1'b1;
      hw_addr = {st_r, bin_r[BinBits-1:0]};
      hw_data = '0;
    end
    if (hclr_busy) begin
      hw_en = ({1'b0, hclr_addr} < (HW+1)'(HD));
      hw_addr = hclr_addr;
      hw_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    hrd_r <= hist_mem[rd_addr];
    if (hw_en) begin
      hist_mem[hw_addr] <= hw_data;
    end
  end

  always_comb begin
    ph_nxt = ph_r;
    bin_nxt = bin_r;
    unique case (ph_r)
      P_IDLE: begin
        if (cmd.start) begin
          bin_nxt = '0;
          if (cmd.req == REQ_SAMPLE) begin
            ph_nxt = P_SAMP;
          end else if (cmd.req == REQ_CLEAR) begin
            ph_nxt = P_SWEEP;
          end else begin
            ph_nxt = cmd.station_ok ? P_SCAN : P_TAIL;
          end
        end
      end
      P_SAMP: ph_nxt = P_IDLE;
      P_SWEEP, P_SCAN: begin
        bin_nxt = bin_r + 1'b1;
        if (bin_r == (BinBits+1)'(NumBins - 1)) begin
          ph_nxt = (ph_r == P_SCAN) ? P_TAIL : P_IDLE;
        end
      end
      P_TAIL: ph_nxt = P_IDLE;
      default: ph_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
      done_r <= 1'b0;
      rd_v_r <= 1'b0;
      init_r <= 1'b1;
      init_cnt_r <= '0;
    end else begin
      ph_r <= ph_nxt;
      done_r <= (ph_r == P_TAIL) || ((ph_r == P_SAMP) || (ph_r == P_SWEEP &&
                bin_r == (BinBits+1)'(NumBins - 1)));
      rd_v_r <= (ph_r == P_SCAN);
      if (init_r) begin
        init_cnt_r <= init_cnt_r + 1'b1;
        if (init_cnt_r == (SW+1)'(NUM_STATIONS - 1)) begin
          init_r <= 1'b0;
        end
      end
    end
  end

  // Scalar stores; reset sweep clears each station once
  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    rbin_r <= bin_r[BinBits-1:0];
    if (ph_r == P_IDLE && cmd.start) begin
      st_r <= station;
      code_r <= code;
      ok_r <= cmd.station_ok;
      best_r <= '0;
      mode_r <= '0;
    end
    if (rd_v_r && hrd_r > best_r) begin
      best_r <= hrd_r;
      mode_r <= decode_temp(rbin_r);
    end
    if (init_r) begin
      min_mem[init_cnt_r[SW-1:0]] <= EMPTY_MIN;
      max_mem[init_cnt_r[SW-1:0]] <= EMPTY_MAX;
      sum_mem[init_cnt_r[SW-1:0]] <= '0;
      cnt_mem[init_cnt_r[SW-1:0]] <= '0;
    end else if (ph_r == P_SAMP) begin
      if (cnt_mem[st_r] < CMAX) begin
        cnt_mem[st_r] <= cnt_mem[st_r] + 1'b1;
      end
      if (t_ext < min_mem[st_r]) begin
        min_mem[st_r] <= t_ext;
      end
      if (t_ext > max_mem[st_r]) begin
        max_mem[st_r] <= t_ext;
      end
      if (sum_w > (SumW+1)'(SUM_HI)) begin
        sum_mem[st_r] <= SUM_HI;
      end else if (sum_w < (SumW+1)'(SUM_LO)) begin
        sum_mem[st_r] <= SUM_LO;
      end else begin
        sum_mem[st_r] <= sum_w[SumW-1:0];
      end
    end else if (ph_r == P_SWEEP && bin_r == '0) begin
      min_mem[st_r] <= EMPTY_MIN;
      max_mem[st_r] <= EMPTY_MAX;
      sum_mem[st_r] <= '0;
      cnt_mem[st_r] <= '0;
    end
  end

  always_comb begin
    res_min = ok_r ? min_mem[st_r] : EMPTY_MIN;
    res_max = ok_r ? max_mem[st_r] : EMPTY_MAX;
    res_sum = ok_r ? sum_mem[st_r] : '0;
    res_count = ok_r ? CntOutW'({{CntOutW{1'b0}}, cnt_mem[st_r]}) : '0;
    res_mode = mode_r;
  end

  assign sts.done = done_r && !init_r;
endmodule

@@ src/pcts_ctrl.sv @@
// Controller: request intake, stall while the histogram is cleared after reset, result register handoff
module pcts_ctrl import pcts_pkg::*; #(
  parameter int NUM_STATIONS = NumStationsDef,
  localparam int SW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1,
  localparam int HW = SW + BinBits
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_station_num,
  input  logic [MaskW-1:0] mask,
  input  logic out_stall,
  output logic out_valid,
  output pcts_cmd_t cmd,
  input  pcts_sts_t sts,
  output logic [SW-1:0] dp_station
);
  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_BUSY = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic query_r;
  logic [HW:0] clr_r;
  logic in_range, mask_bit, take, ok, ignore;

  assign in_range = 32'(in_station_num) < 32'(NUM_STATIONS);
  assign mask_bit = mask[in_station_num];
  assign dp_station = SW'(in_station_num);
  assign in_stall = (state_r != S_IDLE);
  assign take = in_valid && !in_stall;
  assign ok = in_range && (in_req_type == REQ_QUERY || in_req_type == REQ_CLEAR ||
              mask_bit);
  assign ignore = (in_req_type == 2'd3) || !ok && in_req_type != REQ_QUERY;
  assign cmd.start = take && !ignore;
  assign cmd.req = in_req_type;
  assign cmd.station_ok = in_range;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (clr_r[HW]) state_nxt = S_IDLE;
      S_IDLE: if (cmd.start) state_nxt = S_BUSY;
      S_BUSY: if (sts.done) state_nxt = query_r ? S_OUT : S_IDLE;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      clr_r <= '0;
      query_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.start) begin
        query_r <= (in_req_type == REQ_QUERY);
      end
    end
  end
endmodule

@@ src/pcts_hclr.sv @@
// Histogram reset sweep: zero every bin after reset, one per cycle
module pcts_hclr import pcts_pkg::*; #(
  parameter int NUM_STATIONS = NumStationsDef,
  localparam int SW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1,
  localparam int HW = SW + BinBits
) (
  input  logic clk,
  input  logic rst_n,
  output logic busy,
  output logic [HW-1:0] addr
);
  logic [HW:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (!cnt_r[HW]) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end
  assign busy = !cnt_r[HW];
  assign addr = cnt_r[HW-1:0];
endmodule

@@ src/per_channel_temperature_stats_unit.sv @@
// Top level: per-station temperature min/max/sum/count/histogram-mode engine
// A sample keeps in_stall high during one read-modify-write of the station registers
// and the histogram memory; a clear zeroes the station's bins one per cycle; a query
// reads one histogram bin per cycle (none for a station out of range), raises out_valid
// once it is done and holds its result until taken, and the next request is taken the
// cycle after. Ignored requests do not raise in_stall. After reset the block zeroes the
// histogram one entry per cycle, NUM_BINS entries for each station with the station
// count rounded up to a power of two, and keeps in_stall high until that sweep is over;
// cfg writes are taken at any time.
module per_channel_temperature_stats_unit import pcts_pkg::*; #(
  parameter int NUM_STATIONS = NumStationsDef,
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [MaskW-1:0] cfg_automatic_mask,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_req_type,
  input  logic [4:0] in_station_num,
  input  logic [7:0] in_temp_code,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [MinW-1:0] out_stat_min,
  output logic signed [MinW-1:0] out_stat_max,
  output logic signed [SumW-1:0] out_stat_sum,
  output logic [CntOutW-1:0] out_stat_count,
  output logic signed [ModeW-1:0] out_stat_mode
);
  localparam int SW = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;
  logic [MaskW-1:0] mask_r;
  pcts_cmd_t cmd;
  pcts_sts_t sts;
  logic [SW-1:0] dp_station;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mask_r <= cfg_automatic_mask;
    end
  end

  pcts_ctrl #(.NUM_STATIONS(NUM_STATIONS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_req_type, .in_station_num,
    .mask(mask_r), .out_stall, .out_valid, .cmd, .sts, .dp_station
  );

  pcts_datapath #(.NUM_STATIONS(NUM_STATIONS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .station(dp_station), .code(in_temp_code),
    .res_min(out_stat_min), .res_max(out_stat_max), .res_sum(out_stat_sum),
    .res_count(out_stat_count), .res_mode(out_stat_mode)
  );
endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for per_channel_temperature_stats_unit: random and directed requests checked by a scoreboard
`timescale 1ns / 100ps

module tb_top;
  import pcts_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned COUNT_TOP = 65535;
  localparam int LIMIT = 3000000;
  localparam int TAIL = 300;

  typedef struct packed {
    logic signed [MinW-1:0] smin;
    logic signed [MinW-1:0] smax;
    logic signed [SumW-1:0] ssum;
    logic [CntOutW-1:0] scount;
    logic signed [ModeW-1:0] smode;
  } stats_t;

  class stats_scoreboard;
    bit [MaskW-1:0] auto_mask;
    int mn[32];
    int mx[32];
    int sm[32];
    int unsigned cnt[32];
    int unsigned hist[32][256];
    stats_t expected_q[$];
    int errors;
    int results;

    function new();
      auto_mask = '0;
      errors = 0;
      results = 0;
      for (int s = 0; s < 32; s++) clear_station(s);
    endfunction

    function void clear_station(int s);
      mn[s] = 1000;
      mx[s] = -1000;
      sm[s] = 0;
      cnt[s] = 0;
      for (int b = 0; b < 256; b++) hist[s][b] = 0;
    endfunction

    function int decode(bit [7:0] code);
      return code[7] ? -int'(code[6:0]) : int'(code[6:0]);
    endfunction

    function void note_request(bit [1:0] req, bit [4:0] st, bit [7:0] code);
      int t;
      int unsigned best;
      int mode;
      stats_t e;
      case (req)
        REQ_SAMPLE: begin
          if (auto_mask[st]) begin
            if (hist[st][code] < COUNT_TOP) hist[st][code]++;
            if (cnt[st] < COUNT_TOP) cnt[st]++;
            t = decode(code);
            if (t < mn[st]) mn[st] = t;
            if (t > mx[st]) mx[st] = t;
            sm[st] = sm[st] + t;
            if (sm[st] > 8388607) sm[st] = 8388607;
            if (sm[st] < -8388608) sm[st] = -8388608;
          end
        end
        REQ_CLEAR: clear_station(st);
        REQ_QUERY: begin
          best = 0;
          mode = 0;
          for (int b = 0; b < 256; b++) begin
            if (hist[st][b] > best) begin
              best = hist[st][b];
              mode = decode(b[7:0]);
            end
          end
          e.smin = MinW'(mn[st]);
          e.smax = MinW'(mx[st]);
          e.ssum = SumW'(sm[st]);
          e.scount = CntOutW'(cnt[st]);
          e.smode = ModeW'(mode);
          expected_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(stats_t got);
      stats_t e;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result min=%0d max=%0d sum=%0d cnt=%0d mode=%0d",
          got.smin, got.smax, got.ssum, got.scount, got.smode);
        return;
      end
      e = expected_q.pop_front();
      if (got.smin !== e.smin || got.smax !== e.smax || got.ssum !== e.ssum ||
          got.scount !== e.scount || got.smode !== e.smode) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp min=%0d max=%0d sum=%0d cnt=%0d mode=%0d",
            e.smin, e.smax, e.ssum, e.scount, e.smode);
          $display("          got min=%0d max=%0d sum=%0d cnt=%0d mode=%0d",
            got.smin, got.smax, got.ssum, got.scount, got.smode);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [MaskW-1:0] cfg_automatic_mask;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_req_type;
  logic [4:0] in_station_num;
  logic [7:0] in_temp_code;
  logic out_valid;
  logic out_stall;
  logic signed [MinW-1:0] out_stat_min;
  logic signed [MinW-1:0] out_stat_max;
  logic signed [SumW-1:0] out_stat_sum;
  logic [CntOutW-1:0] out_stat_count;
  logic signed [ModeW-1:0] out_stat_mode;

  stats_scoreboard sb;
  int send_idle;
  int stall_pct;
  int hold_left;
  int cycles;
  int sent;
  int unsigned req_seen[4];

  per_channel_temperature_stats_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_automatic_mask(cfg_automatic_mask),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_station_num(in_station_num),
    .in_temp_code(in_temp_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_stat_min(out_stat_min),
    .out_stat_max(out_stat_max),
    .out_stat_sum(out_stat_sum),
    .out_stat_count(out_stat_count),
    .out_stat_mode(out_stat_mode)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    sb = new();
    send_idle = 0;
    stall_pct = 0;
    hold_left = 0;
    cycles = 0;
    sent = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** per_channel_temperature_stats_unit: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(in_req_type, in_station_num, in_temp_code);
      req_seen[in_req_type]++;
    end
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_stat_min, out_stat_max, out_stat_sum, out_stat_count, out_stat_mode});
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(input logic [1:0] req, input logic [4:0] st, input logic [7:0] code);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_station_num <= st;
    in_temp_code <= code;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic write_mask(input logic [MaskW-1:0] mask);
    drain();
    repeat (TAIL) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_automatic_mask <= mask;
    do @(posedge clk); while (!cfg_ready);
    sb.auto_mask = mask;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    logic [4:0] st;
    r = $urandom_range(99);
    st = ($urandom_range(1) == 1) ? 5'($urandom_range(3)) : 5'($urandom_range(31));
    if (r < 72) send_item(REQ_SAMPLE, st, 8'($urandom_range(255)));
    else if (r < 78) send_item(REQ_CLEAR, st, 8'($urandom_range(255)));
    else if (r < 95) send_item(REQ_QUERY, st, 8'($urandom_range(255)));
    else send_item(REQ_UNUSED, st, 8'($urandom_range(255)));
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    send_idle = idle;
    stall_pct = stall;
    repeat (n) random_item();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_automatic_mask = '0;
    in_valid = 1'b0;
    in_req_type = REQ_SAMPLE;
    in_station_num = '0;
    in_temp_code = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // mask still zero: samples dropped, queries return empty values
    send_item(REQ_SAMPLE, 5'd0, 8'h05);
    send_item(REQ_QUERY, 5'd0, 8'h00);
    send_item(REQ_UNUSED, 5'd1, 8'hff);
    write_mask(32'hffff_ffff);
    send_item(REQ_SAMPLE, 5'd0, 8'h00);
    send_item(REQ_SAMPLE, 5'd0, 8'h80);
    send_item(REQ_SAMPLE, 5'd0, 8'h7f);
    send_item(REQ_SAMPLE, 5'd0, 8'hff);
    send_item(REQ_SAMPLE, 5'd0, 8'hff);
    send_item(REQ_QUERY, 5'd0, 8'h00);
    send_item(REQ_SAMPLE, 5'd31, 8'h81);
    send_item(REQ_SAMPLE, 5'd31, 8'h01);
    send_item(REQ_QUERY, 5'd31, 8'hff);
    send_item(REQ_CLEAR, 5'd31, 8'h00);
    send_item(REQ_QUERY, 5'd31, 8'h00);
    send_item(REQ_QUERY, 5'd17, 8'h00);
    send_item(REQ_UNUSED, 5'd0, 8'h00);
    send_item(REQ_QUERY, 5'd0, 8'h00);
    write_mask(32'h0000_0001);
    send_item(REQ_SAMPLE, 5'd2, 8'h10);
    send_item(REQ_CLEAR, 5'd0, 8'h00);
    send_item(REQ_QUERY, 5'd2, 8'h00);
    send_item(REQ_QUERY, 5'd0, 8'h00);

    write_mask(32'hffff_ffff);
    run_phase(260, 0, 0);
    write_mask($urandom);
    run_phase(260, 61, 0);
    write_mask(32'h5555_aaaa ^ $urandom);
    run_phase(130, 0, 61);

    // hold the receiver off while queries keep coming
    hold_left = 3000;
    send_idle = 0;
    repeat (20) send_item(REQ_QUERY, 5'($urandom_range(31)), 8'($urandom));
    drain();
    run_phase(130, 0, 61);
    write_mask(32'hffff_ffff);
    run_phase(230, 8, 8);

    drain();
    repeat (TAIL) @(negedge clk);
    $display("requests sent %0d (samples %0d, clears %0d, queries %0d, unused %0d)",
      sent, req_seen[0], req_seen[1], req_seen[2], req_seen[3]);
    $display("results checked %0d, mismatches %0d, left over %0d",
      sb.results, sb.errors, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("** per_channel_temperature_stats_unit: PASSED **");
    else
      $display("** per_channel_temperature_stats_unit: FAILED **");
    $finish;
  end
endmodule

@@ filelist.f @@
src/pcts_pkg.sv
src/pcts_datapath.sv
src/pcts_ctrl.sv
src/pcts_hclr.sv
src/per_channel_temperature_stats_unit.sv
tb/sv/tb_top.sv
